/* rtl/pnct_pkg.sv */
// shared types and constants for the png chunk stream tracker
// no dependencies; imported by every rtl module of the block

package pnct_pkg;

    // location codes as reported on the result beat
    localparam logic [1:0] LOC_SIG  = 2'd0;
    localparam logic [1:0] LOC_HDR  = 2'd1;
    localparam logic [1:0] LOC_DATA = 2'd2;
    localparam logic [1:0] LOC_CRC  = 2'd3;

    // section sizes: last byte positions of a 3-bit counter, and the longest signature
    localparam logic [2:0] HDR_LAST_POS = 3'd7;
    localparam logic [2:0] CRC_LAST_POS = 3'd3;
    localparam logic [3:0] SIG_MAX_LEN  = 4'd8;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 4;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIG_LENGTH = 2'd1;

    // stream widths
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 72;
    localparam int unsigned OUT_TUSER_W = 3;

    // place in the stream, one-hot
    typedef enum logic [3:0] {
        PL_SIG  = 4'b0001,
        PL_HDR  = 4'b0010,
        PL_DATA = 4'b0100,
        PL_CRC  = 4'b1000
    } t_place;

    // one tagged byte
    typedef struct packed {
        logic [31:0] chunk_type;
        logic [31:0] chunk_length;
        logic        is_writing;
        logic [1:0]  location;
        logic [7:0]  byte_out;
        logic        section_last;
    } t_result;

endpackage

/* rtl/pnct_tracker.sv */
// chunk framing state of the png chunk stream tracker
// depends on pnct_pkg; state advances once per accepted byte

module pnct_tracker
    import pnct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_stream,
    input  logic        i_direction,
    input  logic [3:0]  i_sig_length,
    output t_result     o_result
);

    t_place      r_place, n_place;
    logic [2:0]  r_byte_count, n_byte_count;
    logic [55:0] r_header, n_header;
    logic [31:0] r_data_remaining, n_data_remaining;
    logic [31:0] r_cur_type, n_cur_type;
    logic [31:0] r_cur_length, n_cur_length;

    t_place      w_place;
    logic [2:0]  w_count;
    logic [3:0]  w_sig_eff;
    logic [63:0] w_hdr_full;
    logic [31:0] w_remain_dec;
    logic        w_last;
    logic [1:0]  w_loc;

    always_comb begin
        w_sig_eff    = (i_sig_length > SIG_MAX_LEN) ? SIG_MAX_LEN : i_sig_length;
        w_hdr_full   = {r_header, i_data_byte};
        w_remain_dec = r_data_remaining - 32'd1;

        // restart, then skip an empty signature
        w_place = i_start_stream ? PL_SIG : r_place;
        w_count = i_start_stream ? 3'd0 : r_byte_count;
        if (w_place == PL_SIG && w_sig_eff == 4'd0) begin
            w_place = PL_HDR;
            w_count = 3'd0;
        end

        n_place          = w_place;
        n_byte_count     = w_count;
        n_header         = r_header;
        n_data_remaining = r_data_remaining;
        n_cur_type       = r_cur_type;
        n_cur_length     = r_cur_length;
        w_last           = 1'b0;
        w_loc            = LOC_SIG;

        unique case (w_place)
            PL_SIG: begin
                w_loc = LOC_SIG;
                if (({1'b0, w_count} + 4'd1) >= w_sig_eff) begin
                    w_last       = 1'b1;
                    n_place      = PL_HDR;
                    n_byte_count = 3'd0;
                end else begin
                    n_byte_count = w_count + 3'd1;
                end
            end
            PL_HDR: begin
                w_loc    = LOC_HDR;
                n_header = w_hdr_full[55:0];
                if (w_count >= HDR_LAST_POS) begin
                    w_last           = 1'b1;
                    n_cur_length     = w_hdr_full[63:32];
                    n_cur_type       = w_hdr_full[31:0];
                    n_data_remaining = w_hdr_full[63:32];
                    n_byte_count     = 3'd0;
                    n_place          = (w_hdr_full[63:32] == 32'd0) ? PL_CRC : PL_DATA;
                end else begin
                    n_byte_count = w_count + 3'd1;
                end
            end
            PL_DATA: begin
                w_loc            = LOC_DATA;
                n_data_remaining = w_remain_dec;
                if (w_remain_dec == 32'd0) begin
                    w_last       = 1'b1;
                    n_place      = PL_CRC;
                    n_byte_count = 3'd0;
                end
            end
            PL_CRC: begin
                w_loc = LOC_CRC;
                if (w_count >= CRC_LAST_POS) begin
                    w_last       = 1'b1;
                    n_place      = PL_HDR;
                    n_byte_count = 3'd0;
                end else begin
                    n_byte_count = w_count + 3'd1;
                end
            end
            default: begin
                w_loc = LOC_SIG;
            end
        endcase

        o_result.byte_out     = i_data_byte;
        o_result.location     = w_loc;
        o_result.is_writing   = i_direction;
        o_result.chunk_length = n_cur_length;
        o_result.chunk_type   = n_cur_type;
        o_result.section_last = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_place          <= PL_SIG;
            r_byte_count     <= 3'd0;
            r_data_remaining <= 32'd0;
            r_cur_type       <= 32'd0;
            r_cur_length     <= 32'd0;
        end else if (i_accept) begin
            r_place          <= n_place;
            r_byte_count     <= n_byte_count;
            r_data_remaining <= n_data_remaining;
            r_cur_type       <= n_cur_type;
            r_cur_length     <= n_cur_length;
        end
    end

    // header shift register is overwritten fully before any use
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_header <= n_header;
        end
    end

    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_place == PL_DATA |-> r_data_remaining != 32'd0)
        else $error("data place with no bytes remaining");

    a_crc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_place == PL_CRC |-> r_byte_count <= CRC_LAST_POS)
        else $error("crc byte count out of range");

endmodule

/* rtl/pnct_out_stage.sv */
// result register with skid entry for the png chunk stream tracker
// depends on pnct_pkg for the result struct

module pnct_out_stage
    import pnct_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid || i_ready) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_valid || i_ready) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= i_data;
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry filled while main register empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && i_ready |=> !r_skid_valid && r_main_valid)
        else $error("skid entry not moved on downstream take");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_main_valid && !i_ready |=> r_main_valid)
        else $error("result lost while stalled");

endmodule

/* rtl/png_chunk_stream_tracker.sv */
// top level of the png chunk stream tracker
// depends on pnct_pkg, pnct_tracker and pnct_out_stage
//
// usage:
//   the slave stream carries one png byte per beat in s_axis_tdata; s_axis_tuser
//   set on a beat restarts tracking at the signature before that byte.
//   the master stream returns exactly one beat per input byte: the byte, its
//   location (signature, chunk header, chunk data, chunk crc), the direction
//   flag, the current chunk length and type, and tlast on the final byte of
//   each section (signature, header, data, crc).
//   the result is registered: a byte accepted at an edge while the receiver keeps
//   up is on the master side after that edge. throughput is one byte per cycle
//   while s_axis_tready is high; the framing state advances for each accepted byte.
//   when the receiver stalls, the result register holds and one more byte
//   lands in a skid entry; s_axis_tready drops only while that entry is full.
//   configuration (direction, signature length) is written through the plain
//   write port while the stream is idle; indexes beyond the list are ignored.
//   synchronous active-low reset returns to the signature place with zero
//   length and type, direction reading and an eight byte signature.

module png_chunk_stream_tracker
    import pnct_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // byte input stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic                    s_axis_tuser,   // [0] start_stream
    // tagged byte output stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // [7:0] byte_out, [39:8] chunk_length,
                                                    // [71:40] chunk_type
    output logic [OUT_TUSER_W-1:0]  m_axis_tuser,   // [1:0] location, [2] is_writing
    output logic                    m_axis_tlast    // section_last
);

    logic       r_direction;
    logic [3:0] r_sig_length;

    logic       w_in_accept;
    t_result    w_result;
    t_result    w_out;

    // configuration registers, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= 1'b0;
            r_sig_length <= SIG_MAX_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DIRECTION:  r_direction  <= i_cfg_data[0];
                REG_SIG_LENGTH: r_sig_length <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign w_in_accept = s_axis_tvalid && s_axis_tready;

    // framing state and per-byte tagging
    pnct_tracker u_tracker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_in_accept),
        .i_data_byte    (s_axis_tdata[7:0]),
        .i_start_stream (s_axis_tuser),
        .i_direction    (r_direction),
        .i_sig_length   (r_sig_length),
        .o_result       (w_result)
    );

    // result register and skid entry
    pnct_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (w_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {w_out.chunk_type, w_out.chunk_length, w_out.byte_out};
    assign m_axis_tuser = {w_out.is_writing, w_out.location};
    assign m_axis_tlast = w_out.section_last;

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for png_chunk_stream_tracker
// depends on pnct_pkg and the rtl of the block; a small class predicts the tag of every beat

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pnct_pkg::*;

    // tracks png framing byte by byte and keeps the tags still owed by the block
    class chunk_tagger;
        logic        dir_reg;
        logic [3:0]  sig_len_reg;
        logic [1:0]  place;
        logic [2:0]  byte_count;
        logic [63:0] header_shift;
        logic [31:0] data_left;
        logic [31:0] cur_length;
        logic [31:0] cur_type;
        t_result     tags_due[$];
        int          mismatches;

        function new();
            dir_reg      = 1'b0;
            sig_len_reg  = SIG_MAX_LEN;
            place        = LOC_SIG;
            byte_count   = '0;
            header_shift = '0;
            data_left    = '0;
            cur_length   = '0;
            cur_type     = '0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_DIRECTION) begin
                dir_reg = val[0];
            end else if (idx == REG_SIG_LENGTH) begin
                sig_len_reg = val;
            end
            // other indexes are ignored by the block
        endfunction

        function void take_byte(logic [7:0] b, logic restart);
            t_result    tag;
            logic [3:0] sig_bytes;
            logic [1:0] loc;
            logic       last;
            sig_bytes = (sig_len_reg > SIG_MAX_LEN) ? SIG_MAX_LEN : sig_len_reg;
            last      = 1'b0;
            if (restart) begin
                place      = LOC_SIG;
                byte_count = '0;
            end
            // no signature: the byte already belongs to the first header
            if (place == LOC_SIG && sig_bytes == 4'd0) begin
                place      = LOC_HDR;
                byte_count = '0;
            end
            loc = place;
            case (place)
                LOC_SIG: begin
                    if ({1'b0, byte_count} + 4'd1 >= sig_bytes) begin
                        last       = 1'b1;
                        place      = LOC_HDR;
                        byte_count = '0;
                    end else begin
                        byte_count = byte_count + 3'd1;
                    end
                end
                LOC_HDR: begin
                    header_shift = {header_shift[55:0], b};
                    if (byte_count == HDR_LAST_POS) begin
                        last       = 1'b1;
                        cur_length = header_shift[63:32];
                        cur_type   = header_shift[31:0];
                        data_left  = cur_length;
                        byte_count = '0;
                        place      = (cur_length == 32'd0) ? LOC_CRC : LOC_DATA;
                    end else begin
                        byte_count = byte_count + 3'd1;
                    end
                end
                LOC_DATA: begin
                    data_left = data_left - 32'd1;
                    if (data_left == 32'd0) begin
                        last       = 1'b1;
                        place      = LOC_CRC;
                        byte_count = '0;
                    end
                end
                default: begin
                    if (byte_count >= CRC_LAST_POS) begin
                        last       = 1'b1;
                        place      = LOC_HDR;
                        byte_count = '0;
                    end else begin
                        byte_count = byte_count + 3'd1;
                    end
                end
            endcase
            tag.byte_out     = b;
            tag.location     = loc;
            tag.is_writing   = dir_reg;
            tag.chunk_length = cur_length;
            tag.chunk_type   = cur_type;
            tag.section_last = last;
            tags_due.push_back(tag);
        endfunction

        function void check_tagged_byte(logic [OUT_TDATA_W-1:0] td,
                                        logic [OUT_TUSER_W-1:0] tu, logic tl);
            t_result due;
            if (tags_due.size() == 0) begin
                $error("tagged byte %h arrived with no input byte waiting", td[7:0]);
                mismatches++;
            end else begin
                due = tags_due.pop_front();
                if (td[7:0] !== due.byte_out) begin
                    $error("byte_out mismatch: expected %h, actual %h", due.byte_out, td[7:0]);
                    mismatches++;
                end
                if (tu[1:0] !== due.location) begin
                    $error("location mismatch: expected %0d, actual %0d", due.location, tu[1:0]);
                    mismatches++;
                end
                if (tu[2] !== due.is_writing) begin
                    $error("is_writing mismatch: expected %b, actual %b", due.is_writing, tu[2]);
                    mismatches++;
                end
                if (td[39:8] !== due.chunk_length) begin
                    $error("chunk_length mismatch: expected %h, actual %h",
                           due.chunk_length, td[39:8]);
                    mismatches++;
                end
                if (td[71:40] !== due.chunk_type) begin
                    $error("chunk_type mismatch: expected %h, actual %h",
                           due.chunk_type, td[71:40]);
                    mismatches++;
                end
                if (tl !== due.section_last) begin
                    $error("section_last mismatch: expected %b, actual %b", due.section_last, tl);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return tags_due.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;     // [7:0] data_byte
    logic                   s_axis_tuser;     // [0] start_stream
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;     // [7:0] byte_out, [39:8] chunk_length,
                                              // [71:40] chunk_type
    logic [OUT_TUSER_W-1:0] m_axis_tuser;     // [1:0] location, [2] is_writing
    logic                   m_axis_tlast;     // section_last

    chunk_tagger tagger = new();

    // stimulus controls shared between the driver and the sink
    bit idle_on;          // random gaps on both sides
    bit stall_request;    // ask the sink for one long hold-off
    bit restart_next;     // next byte carries the start flag
    int bytes_sent;
    int sig_count;        // signature bytes the block expects under the current setting

    png_chunk_stream_tracker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // sink: random back-pressure, or one long hold-off when asked
    initial begin
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && stall_request) begin
                hold_left     = 60;
                stall_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_on) begin
                m_axis_tready <= ($urandom_range(0, 99) >= 25);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // every output beat is checked against the oldest pending tag
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tagger.check_tagged_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // one byte beat; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        logic st;
        st           = restart_next;
        restart_next = 1'b0;
        if (idle_on) begin
            while ($urandom_range(0, 99) < 25) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tagger.take_byte(b, st);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // register write, only while the stream is idle
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        tagger.write_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // stop offering and wait for every tag to come out
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (tagger.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic send_signature();
        for (int i = 0; i < sig_count; i++) send_byte(8'($urandom_range(0, 255)));
    endtask

    // header big-endian, then data and crc; a cut chunk stops after at most six of its data bytes
    task automatic send_chunk(input logic [31:0] len, input logic [31:0] typ, input bit whole);
        logic [63:0] hdr;
        int          n_data;
        hdr = {len, typ};
        for (int i = 7; i >= 0; i--) send_byte(hdr[8*i +: 8]);
        if (whole) begin
            for (int i = 0; i < int'(len); i++) send_byte(8'($urandom_range(0, 255)));
            for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(0, 255)));
        end else begin
            n_data = $urandom_range(0, 6);
            for (int i = 0; i < n_data && i < len; i++) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // well-formed stream: restart, signature, n_chunks chunks, mostly of length 0 to 16, now and then 17 to 200
    task automatic send_png(input int n_chunks);
        logic [31:0] len;
        restart_next = 1'b1;
        send_signature();
        for (int c = 0; c < n_chunks; c++) begin
            if ($urandom_range(0, 19) == 0) len = $urandom_range(17, 200);
            else len = $urandom_range(0, 16);
            send_chunk(len, $urandom(), 1'b1);
        end
    endtask

    initial begin
        static logic [3:0] phase_sig_len [7] = '{4'd8, 4'd0, 4'd1, 4'd15, 4'd9, 4'd3, 4'd7};
        static logic [7:0] png_sig [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};
        int         phase_end;
        int         pick;
        int         n_noise;
        int         drain_cycles;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_DIRECTION;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        idle_on       = 1'b1;
        stall_request = 1'b0;
        restart_next  = 1'b0;
        bytes_sent    = 0;
        sig_count     = 8;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset settings, real signature, zero-length chunk straight to crc,
        // then a restart in the middle of a header (length and type must be kept)
        restart_next = 1'b1;
        foreach (png_sig[i]) send_byte(png_sig[i]);
        send_chunk(32'd0, 32'h49454E44, 1'b1);
        send_byte(8'hFF);
        restart_next = 1'b1;
        send_byte(8'h00);
        wait_idle();

        // random phases, each under its own setting; extremes 0 and 15 among them
        for (int p = 0; p < 7; p++) begin
            write_cfg(REG_DIRECTION, {3'($urandom_range(0, 7)), 1'(p)});
            write_cfg(REG_SIG_LENGTH, phase_sig_len[p]);
            if (p == 2 || p == 4) begin
                // writes to indexes past the list must change nothing
                write_cfg(CFG_IDX_W'(2), 4'($urandom_range(0, 15)));
                write_cfg(CFG_IDX_W'(3), 4'($urandom_range(0, 15)));
            end
            sig_count = (phase_sig_len[p] > SIG_MAX_LEN) ? int'(SIG_MAX_LEN)
                                                         : int'(phase_sig_len[p]);
            idle_on   = (p != 3);    // phase 3 runs back to back on both sides
            phase_end = bytes_sent + 215;
            while (bytes_sent < phase_end) begin
                if ((p == 1 || p == 5) && bytes_sent > phase_end - 120) stall_request = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    send_png($urandom_range(1, 4));
                end else if (pick < 85) begin
                    // broken stream: header with any length and type, cut off early
                    restart_next = ($urandom_range(0, 3) != 0);
                    send_signature();
                    send_chunk($urandom(), $urandom(), 1'b0);
                end else begin
                    // noise with stray start flags
                    n_noise = $urandom_range(1, 12);
                    for (int i = 0; i < n_noise; i++) begin
                        restart_next = ($urandom_range(0, 9) == 0);
                        send_byte(8'($urandom_range(0, 255)));
                    end
                end
            end
            wait_idle();
        end

        drain_cycles = 0;
        while (tagger.pending() != 0 && drain_cycles < 20000) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (5) @(negedge i_clk);
        if (tagger.pending() != 0) begin
            $error("%0d tagged bytes never came out", tagger.pending());
            tagger.mismatches++;
        end
        if (tagger.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
